// File: rtl/dbre_pkg.sv
package dbre_pkg;

  localparam int SLOTS_DEFAULT = 64;

  localparam int ACTION_W = 2;
  localparam int SLOT_W   = 6;
  localparam int LENGTH_W = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [ACTION_W-1:0] {
    ACT_MARK  = 2'd0,
    ACT_FLUSH = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INSTANCE_COUNT     = 2'd0,
    REG_INSTANCING_ENABLED = 2'd1
  } reg_idx_e;

  typedef enum logic [2:0] {
    OP_MARK_OK  = 3'd0,
    OP_MARK_REJ = 3'd1,
    OP_FLUSH    = 3'd2,
    OP_CLEAR    = 3'd3,
    OP_IGNORE   = 3'd4
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

  typedef struct packed {
    logic                accepted;
    logic [SLOT_W-1:0]   run_start;
    logic [LENGTH_W-1:0] run_length;
    logic                last;
  } res_t;

endpackage

// File: rtl/dirty_bitmap_run_extractor.sv
// Dirty-slot tracker that reports coalesced runs. Words enter a two-entry
// command queue, so the input side keeps taking words while a result waits
// on the output register, until the queue is full. Mark, clear and unused
// action words are handled in the back end at one word per cycle while the
// output is not stalled. A flush leaves the queue and then reports each run
// in two steps (one to find the next dirty slot, one to find the end of its
// run and retire it), or a single empty result when the bitmap is empty. The
// bitmap lives in flip-flops and is clear as soon as reset is released.
module dirty_bitmap_run_extractor #(
  parameter int SLOTS = dbre_pkg::SLOTS_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dbre_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dbre_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [dbre_pkg::ACTION_W-1:0]   action_i,
  input  logic [dbre_pkg::SLOT_W-1:0]     slot_index_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            accepted_o,
  output logic [dbre_pkg::SLOT_W-1:0]     run_start_o,
  output logic [dbre_pkg::LENGTH_W-1:0]   run_length_o,
  output logic                            last_o
);

  logic           q_full;
  logic           q_empty;
  logic           push;
  logic           pop;
  dbre_pkg::cmd_t push_cmd;
  dbre_pkg::cmd_t head_cmd;
  dbre_pkg::res_t res;

  dbre_front #(.SLOTS(SLOTS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .slot_index_i (slot_index_i),
    .full_i       (q_full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  dbre_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (head_cmd)
  );

  dbre_back #(.SLOTS(SLOTS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign accepted_o   = res.accepted;
  assign run_start_o  = res.run_start;
  assign run_length_o = res.run_length;
  assign last_o       = res.last;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !accepted_o |-> run_length_o == '0 && run_start_o == '0 && last_o)
    else $error("Refused or empty result carries run data or is not last.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> accepted_o && run_length_o != '0)
    else $error("A result that is not last is not a run.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && run_length_o != '0 |->
      ({2'b00, run_start_o} + {1'b0, run_length_o}) <= 8'(SLOTS))
    else $error("Reported run reaches beyond the last slot.");

endmodule

// File: rtl/dbre_front.sv
module dbre_front #(
  parameter int SLOTS = dbre_pkg::SLOTS_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dbre_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dbre_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [dbre_pkg::ACTION_W-1:0]   action_i,
  input  logic [dbre_pkg::SLOT_W-1:0]     slot_index_i,
  input  logic                            full_i,
  output logic                            push_o,
  output dbre_pkg::cmd_t                  cmd_o
);

  logic [dbre_pkg::LENGTH_W-1:0] count_q, count_d;
  logic                          enable_q, enable_d;
  logic                          mark_ok;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    count_d  = count_q;
    enable_d = enable_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        dbre_pkg::REG_INSTANCE_COUNT:     count_d  = cfg_data_i;
        dbre_pkg::REG_INSTANCING_ENABLED: enable_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      enable_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      enable_q <= enable_d;
    end
  end

  assign mark_ok = enable_q
                && ({1'b0, slot_index_i} < count_q)
                && ({1'b0, slot_index_i} < dbre_pkg::LENGTH_W'(SLOTS));

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    cmd_o.slot = slot_index_i;
    unique case (action_i)
      dbre_pkg::ACT_MARK:  cmd_o.op = mark_ok ? dbre_pkg::OP_MARK_OK : dbre_pkg::OP_MARK_REJ;
      dbre_pkg::ACT_FLUSH: cmd_o.op = dbre_pkg::OP_FLUSH;
      dbre_pkg::ACT_CLEAR: cmd_o.op = dbre_pkg::OP_CLEAR;
      default:             cmd_o.op = dbre_pkg::OP_IGNORE;
    endcase
  end

endmodule

// File: rtl/dbre_queue.sv
module dbre_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dbre_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output dbre_pkg::cmd_t head_o
);

  dbre_pkg::cmd_t                entries_q [dbre_pkg::QUEUE_DEPTH];
  logic [dbre_pkg::QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [dbre_pkg::QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [dbre_pkg::QCNT_W-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == dbre_pkg::QCNT_W'(dbre_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/dbre_back.sv
module dbre_back #(
  parameter int SLOTS = dbre_pkg::SLOTS_DEFAULT
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  dbre_pkg::cmd_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output dbre_pkg::res_t res_o
);

  localparam int IdxW = $clog2(SLOTS);
  localparam int CntW = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_START = 3'b010,
    S_END   = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [SLOTS-1:0]  bitmap_q, bitmap_d;
  logic [IdxW-1:0]   start_q, start_d;
  logic              out_valid_q, out_valid_d;
  dbre_pkg::res_t    res_q, res_d;
  logic              out_free;
  logic              emit;
  logic [SLOTS-1:0]  zeros;
  logic [SLOTS-1:0]  keep_mask;
  logic [SLOTS-1:0]  remaining;
  logic [CntW-1:0]   end_cnt;
  logic [IdxW-1:0]   first_set;
  logic [IdxW-1:0]   first_zero;

  function automatic logic [IdxW-1:0] find_first(input logic [SLOTS-1:0] v);
    logic [IdxW-1:0] r;
    r = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = IdxW'(i);
      end
    end
    return r;
  endfunction

  assign out_free   = !out_valid_q || !out_stall_i;
  assign first_set  = find_first(bitmap_q);
  assign zeros      = ~bitmap_q & ({SLOTS{1'b1}} << start_q);
  assign first_zero = find_first(zeros);
  assign end_cnt    = (zeros == '0) ? CntW'(SLOTS) : CntW'(first_zero);
  assign keep_mask  = (zeros == '0) ? '0 : ({SLOTS{1'b1}} << first_zero);
  assign remaining  = bitmap_q & keep_mask;

  always_comb begin
    state_d  = state_q;
    bitmap_d = bitmap_q;
    start_d  = start_q;
    pop_o    = 1'b0;
    emit     = 1'b0;
    res_d    = '{accepted: 1'b0, run_start: '0, run_length: '0, last: 1'b1};
    unique case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          if (head_i.op == dbre_pkg::OP_FLUSH) begin
            pop_o   = 1'b1;
            state_d = S_START;
          end else if (out_free) begin
            pop_o = 1'b1;
            emit  = 1'b1;
            unique case (head_i.op)
              dbre_pkg::OP_MARK_OK: begin
                res_d.accepted = 1'b1;
                bitmap_d[head_i.slot[IdxW-1:0]] = 1'b1;
              end
              dbre_pkg::OP_CLEAR: bitmap_d = '0;
              default: ;
            endcase
          end
        end
      end
      S_START: begin
        if (bitmap_q == '0) begin
          if (out_free) begin
            emit    = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          start_d = first_set;
          state_d = S_END;
        end
      end
      S_END: begin
        if (out_free) begin
          emit             = 1'b1;
          res_d.accepted   = 1'b1;
          res_d.run_start  = dbre_pkg::SLOT_W'(start_q);
          res_d.run_length = dbre_pkg::LENGTH_W'(end_cnt - CntW'(start_q));
          res_d.last       = (remaining == '0);
          bitmap_d         = remaining;
          state_d          = (remaining == '0) ? S_IDLE : S_START;
        end
      end
      default: state_d = S_IDLE;
    endcase
    out_valid_d = out_free ? emit : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bitmap_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bitmap_q    <= bitmap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    if (emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule
